[hdl/lct_pkg.sv]
package lct_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W   = $clog2(ENTRIES + 1);
	localparam int CAP_W   = 5;
	localparam int WORD_W  = 32;
	localparam int CNT_W   = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
	localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_FIRST = CNT_W'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	typedef struct packed {
		logic                     operation;
		logic signed [WORD_W-1:0] key;
		logic signed [WORD_W-1:0] value;
	} in_word_t;

	typedef struct packed {
		logic                     found;
		logic signed [WORD_W-1:0] read_value;
	} out_word_t;

	// one entry as seen by the scan
	typedef struct packed {
		logic              valid;
		logic [WORD_W-1:0] key;
		logic [WORD_W-1:0] data;
		logic [CNT_W-1:0]  count;
		logic [IDX_W-1:0]  rank;
	} entry_t;

	typedef struct packed {
		logic              hit;
		logic [IDX_W-1:0]  hit_idx;
		logic [WORD_W-1:0] hit_data;
		logic [IDX_W-1:0]  hit_rank;
		logic              vic;
		logic [IDX_W-1:0]  vic_idx;
		logic [CNT_W-1:0]  vic_count;
		logic [IDX_W-1:0]  vic_rank;
		logic              free;
		logic [IDX_W-1:0]  free_idx;
	} scan_res_t;

	typedef struct packed {
		logic              en;
		logic              is_put;
		logic [WORD_W-1:0] key;
		logic [WORD_W-1:0] value;
		logic [OCC_W-1:0]  cap;
	} upd_cmd_t;

endpackage

[hdl/lct_scan.sv]
module lct_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              step,
	input  logic [lct_pkg::WORD_W-1:0] key,
	input  logic [lct_pkg::IDX_W-1:0]  idx,
	input  lct_pkg::entry_t   entry,
	output lct_pkg::scan_res_t res
);
	import lct_pkg::*;

	logic              hit_q;
	logic              vic_q;
	logic              free_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [WORD_W-1:0] hit_data_q;
	logic [IDX_W-1:0]  hit_rank_q;
	logic [IDX_W-1:0]  vic_idx_q;
	logic [CNT_W-1:0]  vic_count_q;
	logic [IDX_W-1:0]  vic_rank_q;
	logic [IDX_W-1:0]  free_idx_q;

	logic take_hit;
	logic take_vic;
	logic take_free;

	// shared compare: key match, lowest count with oldest rank, first free slot
	always_comb begin
		take_hit  = step && entry.valid && (entry.key == key) && !hit_q;
		take_vic  = step && entry.valid && (!vic_q || (entry.count < vic_count_q) ||
			((entry.count == vic_count_q) && (entry.rank > vic_rank_q)));
		take_free = step && !entry.valid && !free_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			vic_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (start) begin
			hit_q  <= 1'b0;
			vic_q  <= 1'b0;
			free_q <= 1'b0;
		end else begin
			if (take_hit)  hit_q  <= 1'b1;
			if (take_vic)  vic_q  <= 1'b1;
			if (take_free) free_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_hit) begin
			hit_idx_q  <= idx;
			hit_data_q <= entry.data;
			hit_rank_q <= entry.rank;
		end
		if (take_vic) begin
			vic_idx_q   <= idx;
			vic_count_q <= entry.count;
			vic_rank_q  <= entry.rank;
		end
		if (take_free) begin
			free_idx_q <= idx;
		end
	end

	always_comb begin
		res.hit       = hit_q;
		res.hit_idx   = hit_idx_q;
		res.hit_data  = hit_data_q;
		res.hit_rank  = hit_rank_q;
		res.vic       = vic_q;
		res.vic_idx   = vic_idx_q;
		res.vic_count = vic_count_q;
		res.vic_rank  = vic_rank_q;
		res.free      = free_q;
		res.free_idx  = free_idx_q;
	end

endmodule

[hdl/lct_store.sv]
module lct_store (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [lct_pkg::IDX_W-1:0]  rd_idx,
	output lct_pkg::entry_t            rd_entry,
	input  lct_pkg::upd_cmd_t          cmd,
	input  lct_pkg::scan_res_t         res
);
	import lct_pkg::*;

	logic              valid_q [ENTRIES];
	logic [WORD_W-1:0] key_q   [ENTRIES];
	logic [WORD_W-1:0] data_q  [ENTRIES];
	logic [CNT_W-1:0]  cnt_q   [ENTRIES];
	logic [IDX_W-1:0]  rank_q  [ENTRIES];
	logic [OCC_W-1:0]  occ_q;

	logic             do_hit;
	logic             do_evict;
	logic             do_ins;
	logic [OCC_W-1:0] occ_after;
	logic [IDX_W-1:0] ins_idx;

	assign rd_entry.valid = valid_q[rd_idx];
	assign rd_entry.key   = key_q[rd_idx];
	assign rd_entry.data  = data_q[rd_idx];
	assign rd_entry.count = cnt_q[rd_idx];
	assign rd_entry.rank  = rank_q[rd_idx];

	always_comb begin
		do_hit    = cmd.en && res.hit;
		do_evict  = cmd.en && !res.hit && cmd.is_put && (occ_q >= cmd.cap) && res.vic;
		occ_after = occ_q - OCC_W'(do_evict);
		do_ins    = cmd.en && !res.hit && cmd.is_put && (occ_after < cmd.cap) &&
			(do_evict || res.free);
		// the freed victim slot counts as free when it is the lower one
		if (do_evict && (!res.free || (res.vic_idx < res.free_idx)))
			ins_idx = res.vic_idx;
		else
			ins_idx = res.free_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < ENTRIES; j++) valid_q[j] <= 1'b0;
			occ_q <= '0;
		end else begin
			// a victim slot that is refilled at once stays valid
			if (do_evict && !(do_ins && (ins_idx == res.vic_idx)))
				valid_q[res.vic_idx] <= 1'b0;
			if (do_ins)   valid_q[ins_idx]     <= 1'b1;
			occ_q <= occ_after + OCC_W'(do_ins);
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < ENTRIES; j++) begin
			if (do_hit && valid_q[j] && (IDX_W'(j) != res.hit_idx) &&
				(rank_q[j] < res.hit_rank))
				rank_q[j] <= rank_q[j] + IDX_W'(1);
			if ((do_evict || do_ins) && valid_q[j] &&
				!(do_evict && (IDX_W'(j) == res.vic_idx)))
				rank_q[j] <= rank_q[j]
					- IDX_W'(do_evict && (rank_q[j] > res.vic_rank))
					+ IDX_W'(do_ins);
		end
		if (do_hit) begin
			rank_q[res.hit_idx] <= '0;
			if (cnt_q[res.hit_idx] != CNT_MAX)
				cnt_q[res.hit_idx] <= cnt_q[res.hit_idx] + CNT_W'(1);
			if (cmd.is_put)
				data_q[res.hit_idx] <= cmd.value;
		end
		if (do_ins) begin
			key_q[ins_idx]  <= cmd.key;
			data_q[ins_idx] <= cmd.value;
			cnt_q[ins_idx]  <= CNT_FIRST;
			rank_q[ins_idx] <= '0;
		end
	end

endmodule

[hdl/lfu_cache_table_top.sv]
// channel | direction | handshake            | word
// in      | input     | in_valid / in_ready   | in_data   (operation, key, value)
// out     | output    | out_valid / out_ready | out_data  (found, read_value)
// cfg     | input     | cfg_we                | cfg_wdata (capacity_in_use)
//
// each item goes through the accept, a scan of every entry in turn
// through the shared key/count/rank compare, then a write-back
// the result sits in an output register; a new item is taken while it waits
// write-back holds while an earlier result is still not taken
// reset clears valid bits, occupancy and the sequencer; capacity resets to 16
module lfu_cache_table_top (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  lct_pkg::in_word_t        in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output lct_pkg::out_word_t       out_data,
	input  logic                     cfg_we,
	input  logic [lct_pkg::CAP_W-1:0] cfg_wdata
);
	import lct_pkg::*;

	state_t           state_q;
	state_t           state_d;
	logic [IDX_W-1:0] idx_q;
	in_word_t         item_q;
	logic [CAP_W-1:0] cap_q;
	logic             out_valid_q;
	out_word_t        out_q;

	logic       accept;
	logic       scan_step;
	logic       upd_go;
	logic       last_idx;
	entry_t     entry;
	scan_res_t  res;
	upd_cmd_t   cmd;
	logic [OCC_W-1:0] cap_eff;

	assign accept   = in_valid && in_ready;
	assign last_idx = (idx_q == IDX_W'(ENTRIES - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (accept) state_d = ST_SCAN;
			ST_SCAN:   if (last_idx) state_d = ST_UPDATE;
			ST_UPDATE: if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		scan_step = 1'b0;
		upd_go    = 1'b0;
		case (state_q)
			ST_IDLE:   in_ready  = 1'b1;
			ST_SCAN:   scan_step = 1'b1;
			ST_UPDATE: upd_go    = !out_valid_q || out_ready;
			default:   in_ready  = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept)
				idx_q <= '0;
			else if (scan_step && !last_idx)
				idx_q <= idx_q + IDX_W'(1);
			if (cfg_we)
				cap_q <= cfg_wdata;
			if (upd_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_q <= in_data;
		if (upd_go) begin
			out_q.found      <= res.hit;
			out_q.read_value <= (res.hit && (item_q.operation == OP_GET)) ?
				res.hit_data : '0;
		end
	end

	// capacity above the built entry count acts as the entry count
	assign cap_eff = (int'(cap_q) > ENTRIES) ? OCC_W'(ENTRIES) : OCC_W'(cap_q);

	always_comb begin
		cmd.en     = upd_go;
		cmd.is_put = (item_q.operation == OP_PUT);
		cmd.key    = item_q.key;
		cmd.value  = item_q.value;
		cmd.cap    = cap_eff;
	end

	lct_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.step   (scan_step),
		.key    (item_q.key),
		.idx    (idx_q),
		.entry  (entry),
		.res    (res)
	);

	lct_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (idx_q),
		.rd_entry (entry),
		.cmd      (cmd),
		.res      (res)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[hdl/lct_checker.sv]
module lct_checker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  lct_pkg::out_word_t       out_data
);
	import lct_pkg::*;

	// the block is busy right after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready high right after an accepted word");

	// no result can appear the cycle after an accept: the scan must first step through every entry
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !$rose(out_valid))
		else $error("result appeared one cycle after accept");

	// a new result only comes out of a busy block, which is then free again
	a_result_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (in_ready && !$past(in_ready)))
		else $error("result appeared without a finished item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("stalled result dropped or changed");

endmodule

bind lfu_cache_table_top lct_checker u_lct_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
